// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files; only the top level includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/ntsp_pkg.sv -----
// Shared types and constants of the NTS-KE record parser.
`default_nettype none
package ntsp_pkg;
    localparam logic [14:0] RT_END       = 15'd0;
    localparam logic [14:0] RT_NEXTPROTO = 15'd1;
    localparam logic [14:0] RT_ERROR     = 15'd2;
    localparam logic [14:0] RT_AEAD      = 15'd4;
    localparam logic [14:0] RT_COOKIE    = 15'd5;
    localparam logic [14:0] RT_SERVER    = 15'd6;
    localparam logic [14:0] RT_PORT      = 15'd7;

    localparam logic [1:0] KIND_COOKIE  = 2'd0;
    localparam logic [1:0] KIND_SERVER  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY = 2'd2;

    localparam logic [3:0] ST_OK           = 4'd0;
    localparam logic [3:0] ST_BAD_NEXTPROTO = 4'd1;
    localparam logic [3:0] ST_BAD_ERR_SIZE = 4'd2;
    localparam logic [3:0] ST_ERROR_REC    = 4'd3;
    localparam logic [3:0] ST_BAD_AEAD     = 4'd4;
    localparam logic [3:0] ST_BAD_COOKIE   = 4'd5;
    localparam logic [3:0] ST_EMPTY_SERVER = 4'd6;
    localparam logic [3:0] ST_BAD_PORT     = 4'd7;
    localparam logic [3:0] ST_MISS_AEAD    = 4'd8;
    localparam logic [3:0] ST_MISS_COOKIE  = 4'd9;

    localparam int QUEUE_DEPTH = 4;

    // One queued step result: up to a streamed byte and a summary.
    typedef struct packed {
        logic        byte_valid;
        logic [1:0]  byte_kind;
        logic [2:0]  cookie_index;
        logic [7:0]  body_byte;
        logic        body_last;
        logic        sum_valid;
        logic [3:0]  status;
        logic [15:0] error_code;
        logic [15:0] aead_seen;
        logic [15:0] port_value;
        logic [3:0]  cookie_total;
        logic        server_present;
    } step_word_t;
endpackage
`default_nettype wire

// ----- rtl/nts_ke_record_parser.sv -----
// Top level of the NTS-KE record parser.
// The block takes a received NTS-KE message one byte word at a time on the
// input channel (in_valid, in_stall, data_byte, last_in_packet) and splits it
// into records with a four-byte header and a body.
// On the output channel (out_valid, out_stall) it gives cookie and server
// name bytes as they pass, and one summary word per message at the end
// record, the first error, or the byte marked last_in_packet.
// A byte enters in every cycle while the output side keeps up. A streamed
// byte passes through the queue and then the output register after its input
// word is accepted; a byte that carries both a streamed byte and a summary
// yields two output words, byte first and summary second, and that output port sets the sustained rate then.
// A four-entry queue separates the parser from the output register, so the
// input side keeps flowing while an output word waits. When the receiver
// raises out_stall the output holds, the queue fills, and in_stall rises.
// Reset clears the parser, queue and output valid; the AEAD register returns
// to 15 and the next-protocol register to 0. The user must write configuration over
// an APB port at byte addresses 0 and 4 only while the block is idle; the block does not enforce this.
`default_nettype none
module nts_ke_record_parser #(
    parameter int MAX_COOKIES      = 8,
    parameter int COOKIE_BYTES_MAX = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_in_packet,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       item_kind,
    output logic [2:0]       cookie_index,
    output logic [7:0]       body_byte,
    output logic             body_last,
    output logic [3:0]       status,
    output logic [15:0]      error_code,
    output logic [15:0]      aead_seen,
    output logic [15:0]      port_value,
    output logic [3:0]       cookie_total,
    output logic             server_present
);
    import ntsp_pkg::*;

`include "assert_macros.svh"

    localparam logic [2:0] ADDR_AEAD = 3'd0;
    localparam logic [2:0] ADDR_NEXT = 3'd4;

    logic [15:0] aead_cfg_reg;
    logic [15:0] next_cfg_reg;
    logic        cfg_write;

    logic        q_full, q_not_empty, q_push, q_pop;
    step_word_t  q_in, q_head;

    // APB register file: two 16-bit registers, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aead_cfg_reg <= 16'd15;
            next_cfg_reg <= 16'd0;
        end
        else if (cfg_write)
        begin
            if (paddr == ADDR_AEAD)
                aead_cfg_reg <= pwdata[15:0];
            else if (paddr == ADDR_NEXT)
                next_cfg_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr == ADDR_AEAD)
            prdata = {16'd0, aead_cfg_reg};
        else if (paddr == ADDR_NEXT)
            prdata = {16'd0, next_cfg_reg};
    end

    ntsp_front #(
        .MAX_COOKIES      (MAX_COOKIES),
        .COOKIE_BYTES_MAX (COOKIE_BYTES_MAX)
    ) u_front (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .valid                  (in_valid),
        .data_byte              (data_byte),
        .last_in_packet         (last_in_packet),
        .accepted_aead          (aead_cfg_reg),
        .accepted_next_protocol (next_cfg_reg),
        .queue_full             (q_full),
        .stall                  (in_stall),
        .push                   (q_push),
        .push_word              (q_in)
    );

    ntsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    ntsp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .not_empty      (q_not_empty),
        .head           (q_head),
        .pop            (q_pop),
        .stall          (out_stall),
        .valid          (out_valid),
        .item_kind      (item_kind),
        .cookie_index   (cookie_index),
        .body_byte      (body_byte),
        .body_last      (body_last),
        .status         (status),
        .error_code     (error_code),
        .aead_seen      (aead_seen),
        .port_value     (port_value),
        .cookie_total   (cookie_total),
        .server_present (server_present)
    );

    // The queue never takes a word while full and never gives one while empty.
    `ASSERT_NEVER(a_no_overflow, clk, rst_n, q_push && q_full, "queue overflow")
    `ASSERT_NEVER(a_no_underflow, clk, rst_n, q_pop && !q_not_empty, "queue underflow")
    // A summary word never carries a streamed byte.
    `ASSERT_NEVER(a_summary_clean, clk, rst_n, out_valid && item_kind == KIND_SUMMARY && body_last, "summary with body_last")
endmodule
`default_nettype wire

// ----- rtl/ntsp_front.sv -----
// Front part: parses bytes into records and builds queued step results.
`default_nettype none
module ntsp_front #(
    parameter int MAX_COOKIES      = 8,
    parameter int COOKIE_BYTES_MAX = 256
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                valid,
    input  wire logic [7:0]          data_byte,
    input  wire logic                last_in_packet,
    input  wire logic [15:0]         accepted_aead,
    input  wire logic [15:0]         accepted_next_protocol,
    input  wire logic                queue_full,
    output logic                     stall,
    output logic                     push,
    output ntsp_pkg::step_word_t     push_word
);
    import ntsp_pkg::*;

    typedef enum logic [1:0] {PH_HEADER, PH_BODY, PH_DRAIN} phase_t;

    localparam logic [16:0] CookieMax = 17'(COOKIE_BYTES_MAX);
    localparam logic [3:0]  CookieLim = 4'(MAX_COOKIES);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hc_reg, hc_next;
    logic [14:0] type_reg, type_next;
    logic        crit_reg, crit_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] shift_reg, shift_next;
    logic [15:0] aead_reg, aead_next;
    logic [15:0] port_reg, port_next;
    logic [3:0]  ck_reg, ck_next;
    logic        srv_reg, srv_next;

    logic        take;
    logic        sum_hit;
    logic [3:0]  sum_code;
    logic [15:0] ecode;
    logic [15:0] len_full;
    logic        at_end;
    logic [3:0]  fin_code;
    step_word_t  w;

    assign stall = queue_full;
    assign take  = valid && !queue_full;

    always_comb
    begin
        phase_next = phase_reg;
        hc_next    = hc_reg;
        type_next  = type_reg;
        crit_next  = crit_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        aead_next  = aead_reg;
        port_next  = port_reg;
        ck_next    = ck_reg;
        srv_next   = srv_reg;
        sum_hit    = 1'b0;
        sum_code   = ST_OK;
        ecode      = 16'd0;
        len_full   = {len_reg[15:8], data_byte};
        at_end     = (17'(cnt_reg) + 17'd1) == 17'(len_reg);
        w          = '0;
        fin_code   = ST_OK;

        unique case (phase_reg)
            PH_DRAIN:
            begin
            end
            PH_HEADER:
            begin
                hc_next = hc_reg + 2'd1;
                unique case (hc_reg)
                    2'd0:
                    begin
                        crit_next = data_byte[7];
                        type_next = {data_byte[6:0], 8'd0};
                    end
                    2'd1: type_next = {type_reg[14:8], data_byte};
                    2'd2: len_next = {data_byte, 8'd0};
                    default:
                    begin
                        len_next   = len_full;
                        shift_next = 16'd0;
                        cnt_next   = 16'd0;
                        unique case (type_reg)
                            RT_END:
                            begin
                                sum_hit  = 1'b1;
                                sum_code = (aead_reg == 16'd0) ? ST_MISS_AEAD :
                                           (ck_reg == 4'd0) ? ST_MISS_COOKIE : ST_OK;
                            end
                            RT_NEXTPROTO:
                            begin
                                sum_hit  = !crit_reg || len_full != 16'd2;
                                sum_code = ST_BAD_NEXTPROTO;
                            end
                            RT_ERROR:
                            begin
                                sum_hit  = len_full != 16'd2;
                                sum_code = ST_BAD_ERR_SIZE;
                            end
                            RT_AEAD:
                            begin
                                sum_hit  = len_full != 16'd2;
                                sum_code = ST_BAD_AEAD;
                            end
                            RT_COOKIE:
                            begin
                                if (17'(len_full) > CookieMax || ck_reg >= CookieLim)
                                begin
                                    sum_hit  = 1'b1;
                                    sum_code = ST_BAD_COOKIE;
                                end
                                else
                                begin
                                    ck_next = ck_reg + 4'd1;
                                end
                            end
                            RT_SERVER:
                            begin
                                if (len_full == 16'd0)
                                begin
                                    sum_hit  = 1'b1;
                                    sum_code = ST_EMPTY_SERVER;
                                end
                                else
                                begin
                                    srv_next = 1'b1;
                                end
                            end
                            RT_PORT:
                            begin
                                sum_hit  = len_full != 16'd0 && len_full != 16'd2;
                                sum_code = ST_BAD_PORT;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (!sum_hit && len_full != 16'd0)
                            phase_next = PH_BODY;
                    end
                endcase
            end
            default:
            begin
                cnt_next   = cnt_reg + 16'd1;
                shift_next = {shift_reg[7:0], data_byte};
                if (type_reg == RT_COOKIE || type_reg == RT_SERVER)
                begin
                    w.byte_valid   = 1'b1;
                    w.byte_kind    = (type_reg == RT_COOKIE) ? KIND_COOKIE : KIND_SERVER;
                    w.cookie_index = (type_reg == RT_COOKIE) ? 3'(ck_reg - 4'd1) : 3'd0;
                    w.body_byte    = data_byte;
                    w.body_last    = at_end || last_in_packet;
                end
                if (at_end)
                begin
                    unique case (type_reg)
                        RT_NEXTPROTO:
                        begin
                            sum_hit  = shift_next != accepted_next_protocol;
                            sum_code = ST_BAD_NEXTPROTO;
                        end
                        RT_ERROR:
                        begin
                            sum_hit  = 1'b1;
                            sum_code = ST_ERROR_REC;
                            ecode    = shift_next;
                        end
                        RT_AEAD:
                        begin
                            if (shift_next != accepted_aead)
                            begin
                                sum_hit  = 1'b1;
                                sum_code = ST_BAD_AEAD;
                            end
                            else
                            begin
                                aead_next = shift_next;
                            end
                        end
                        RT_PORT: port_next = shift_next;
                        default:
                        begin
                        end
                    endcase
                    phase_next = PH_HEADER;
                    hc_next    = 2'd0;
                end
            end
        endcase

        if (phase_reg != PH_DRAIN)
        begin
            fin_code = (aead_next == 16'd0) ? ST_MISS_AEAD :
                       (ck_next == 4'd0) ? ST_MISS_COOKIE : ST_OK;
            if (!sum_hit && last_in_packet)
            begin
                sum_hit  = 1'b1;
                sum_code = fin_code;
            end
            if (sum_hit)
            begin
                w.sum_valid      = 1'b1;
                w.status         = sum_code;
                w.error_code     = ecode;
                w.aead_seen      = aead_next;
                w.port_value     = port_next;
                w.cookie_total   = ck_next;
                w.server_present = srv_next;
                phase_next       = PH_DRAIN;
            end
        end

        if (last_in_packet && (phase_reg == PH_DRAIN || sum_hit))
        begin
            phase_next = PH_HEADER;
            hc_next    = 2'd0;
            type_next  = 15'd0;
            crit_next  = 1'b0;
            len_next   = 16'd0;
            cnt_next   = 16'd0;
            shift_next = 16'd0;
            aead_next  = 16'd0;
            port_next  = 16'd0;
            ck_next    = 4'd0;
            srv_next   = 1'b0;
        end
    end

    assign push      = take && (w.byte_valid || w.sum_valid);
    assign push_word = w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hc_reg    <= 2'd0;
            type_reg  <= 15'd0;
            crit_reg  <= 1'b0;
            len_reg   <= 16'd0;
            cnt_reg   <= 16'd0;
            shift_reg <= 16'd0;
            aead_reg  <= 16'd0;
            port_reg  <= 16'd0;
            ck_reg    <= 4'd0;
            srv_reg   <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            type_reg  <= type_next;
            crit_reg  <= crit_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            shift_reg <= shift_next;
            aead_reg  <= aead_next;
            port_reg  <= port_next;
            ck_reg    <= ck_next;
            srv_reg   <= srv_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ntsp_queue.sv -----
// Short queue of step results between the parser and the output side.
`default_nettype none
module ntsp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ntsp_pkg::step_word_t push_word,
    input  wire logic                pop,
    output logic                     full,
    output logic                     not_empty,
    output ntsp_pkg::step_word_t     head
);
    import ntsp_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    step_word_t      mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     fill_reg;

    assign full      = fill_reg == (AW+1)'(QUEUE_DEPTH);
    assign not_empty = fill_reg != '0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            fill_reg <= fill_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/ntsp_back.sv -----
// Back part: splits queued step results into output words.
`default_nettype none
module ntsp_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                not_empty,
    input  wire ntsp_pkg::step_word_t head,
    output logic                     pop,
    input  wire logic                stall,
    output logic                     valid,
    output logic [1:0]               item_kind,
    output logic [2:0]               cookie_index,
    output logic [7:0]               body_byte,
    output logic                     body_last,
    output logic [3:0]               status,
    output logic [15:0]              error_code,
    output logic [15:0]              aead_seen,
    output logic [15:0]              port_value,
    output logic [3:0]               cookie_total,
    output logic                     server_present
);
    import ntsp_pkg::*;

    logic byte_done_reg;
    logic load, send_byte, last_part;

    // Streamed byte goes first, then the summary of the same entry.
    assign send_byte = head.byte_valid && !byte_done_reg;
    assign last_part = !send_byte || !head.sum_valid;
    assign load      = not_empty && (!valid || !stall);
    assign pop       = load && last_part;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid         <= 1'b0;
            byte_done_reg <= 1'b0;
        end
        else
        begin
            if (!valid || !stall)
                valid <= not_empty;
            if (load)
                byte_done_reg <= !last_part;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (send_byte)
            begin
                item_kind      <= head.byte_kind;
                cookie_index   <= head.cookie_index;
                body_byte      <= head.body_byte;
                body_last      <= head.body_last;
                status         <= ST_OK;
                error_code     <= 16'd0;
                aead_seen      <= 16'd0;
                port_value     <= 16'd0;
                cookie_total   <= 4'd0;
                server_present <= 1'b0;
            end
            else
            begin
                item_kind      <= KIND_SUMMARY;
                cookie_index   <= 3'd0;
                body_byte      <= 8'd0;
                body_last      <= 1'b0;
                status         <= head.status;
                error_code     <= head.error_code;
                aead_seen      <= head.aead_seen;
                port_value     <= head.port_value;
                cookie_total   <= head.cookie_total;
                server_present <= head.server_present;
            end
        end
    end
endmodule
`default_nettype wire
